@@ design/rbsor_pkg.sv @@
// shared constants and widths for the red-black sor poisson solver
`default_nettype none
package rbsor_pkg;
   localparam int GRID_MAX_DEF = 255;

   // payload widths
   localparam int IDX_W   = 8;
   localparam int VAL_W   = 32;
   localparam int ITER_W  = 16;
   localparam int GAM_W   = 18;
   localparam int TOL_W   = 25;
   localparam int GS_W    = 8;
   localparam int CSR_W   = 25;
   localparam int CSR_A_W = 2;

   // datapath widths
   localparam int SUM_W  = VAL_W + 2;          // sum of four neighbors
   localparam int COEF_W = GAM_W + 1;          // signed gamma or 1-gamma
   localparam int MUL_W  = SUM_W + COEF_W;     // shared multiplier product
   localparam int ACC_W  = MUL_W + 3;          // relaxation accumulator
   localparam int FRAC_SH = 18;                // 2^-42 to 2^-24

   // register reset values
   localparam logic [GAM_W-1:0]  RELAX_RST = GAM_W'(65536);
   localparam logic [TOL_W-1:0]  TOL_RST   = TOL_W'(17);
   localparam logic [ITER_W-1:0] MAXIT_RST = ITER_W'(10000);
   localparam logic [GS_W-1:0]   GRID_RST  = GS_W'(100);
   localparam logic [COEF_W-1:0] ONE_Q16   = COEF_W'(65536);

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_RELAX = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_TOL   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MAXIT = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_GRID  = 2'd3;

   // item and result codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_READ   = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ   = 1'b1;
endpackage
`default_nettype wire

@@ design/red_black_sor_poisson_solver.sv @@
// red-black sor poisson solver: top level with grid memories and solve sequencer
// load item: accepted every cycle while idle
// read item: input stalls through S_RA, S_RB and S_RDRSP until the result is registered
// solve: each point of the current color waits on the one-bit-a-cycle divider for the
//   source term, while each point of the other color is skipped
// input stalls from the last load until the report is taken into the output register
// synchronous reset clears control state and registers; grid memories are not cleared
`default_nettype none
module red_black_sor_poisson_solver #(
   parameter int GRID_MAX = rbsor_pkg::GRID_MAX_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input item channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_func,
   input  wire logic [rbsor_pkg::IDX_W-1:0]     req_row,
   input  wire logic [rbsor_pkg::IDX_W-1:0]     req_col,
   input  wire logic signed [rbsor_pkg::VAL_W-1:0] req_field_value,
   input  wire logic signed [rbsor_pkg::VAL_W-1:0] req_source_value,
   input  wire logic                            req_last_load,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_result_kind,
   output logic signed [rbsor_pkg::VAL_W-1:0]   rsp_point_value,
   output logic [rbsor_pkg::ITER_W-1:0]         rsp_iteration_count,
   output logic                                 rsp_converged,
   // register write port
   input  wire logic                            csr_write_en,
   input  wire logic [rbsor_pkg::CSR_A_W-1:0]   csr_index,
   input  wire logic [rbsor_pkg::CSR_W-1:0]     csr_data
);
   localparam int AW    = $clog2(GRID_MAX + 1);   // bits of one grid index
   localparam int ADR_W = 2 * AW;                 // point address {row, col}
   localparam int DEPTH = 1 << ADR_W;
   localparam int VW    = rbsor_pkg::VAL_W;
   localparam int MW    = rbsor_pkg::MUL_W;
   localparam int AC    = rbsor_pkg::ACC_W;
   localparam int RQ_W  = AC - rbsor_pkg::FRAC_SH;

   typedef enum logic [4:0] {
      S_IDLE, S_RA, S_RB, S_RDRSP, S_SETUP, S_PT, S_RD, S_RDL,
      S_M1, S_M2, S_M3, S_DIV, S_DIVW, S_RND, S_WR, S_REPORT
   } state_type;

   // grid memories
   logic signed [VW-1:0] fld_mem [DEPTH];
   logic signed [VW-1:0] src_mem [DEPTH];

   state_type state_ff;
   logic [rbsor_pkg::GAM_W-1:0]  relax_ff;
   logic [rbsor_pkg::TOL_W-1:0]  tol_ff;
   logic [rbsor_pkg::ITER_W-1:0] maxit_ff;
   logic [rbsor_pkg::GS_W-1:0]   grid_ff;

   logic [ADR_W-1:0]       ctr_addr_ff;
   logic                   inside_ff;
   logic [AW-1:0]          ri_ff, cj_ff, n_ff;
   logic [ADR_W-1:0]       n2_ff;
   logic                   parity_ff;
   logic [rbsor_pkg::ITER_W-1:0] iter_ff;
   logic                   changed_ff;
   logic [2:0]             k_ff;
   logic signed [VW-1:0]   old_ff, g_ff, nv_ff;
   logic signed [rbsor_pkg::SUM_W-1:0] sum_ff;
   logic signed [MW-1:0]   prod_ff;
   logic signed [AC-1:0]   acc_ff, t_ff;
   logic                   neg_ff;
   logic signed [VW-1:0]   fld_rdata_ff, src_rdata_ff;

   logic                   rsp_valid_ff, rsp_kind_ff, rsp_conv_ff;
   logic signed [VW-1:0]   rsp_value_ff;
   logic [rbsor_pkg::ITER_W-1:0] rsp_iter_ff;

   // request decode
   logic                   req_xfer;
   logic                   req_inside;
   logic [ADR_W-1:0]       req_addr;
   logic                   slot_free;

   // memory ports
   logic [ADR_W-1:0]       fld_raddr;
   logic [ADR_W-1:0]       pt_addr;
   logic                   fld_we, src_we;
   logic [ADR_W-1:0]       fld_waddr;
   logic signed [VW-1:0]   fld_wdata;

   // shared multiplier
   logic signed [rbsor_pkg::SUM_W-1:0]  mul_a;
   logic signed [rbsor_pkg::COEF_W-1:0] mul_b;
   logic signed [MW-1:0]   mul_p;
   logic signed [rbsor_pkg::COEF_W-1:0] gam_s;

   // divider
   logic                   div_start, div_done;
   logic [MW-1:0]          div_numer, div_quot, prod_mag;

   // rounding and change test
   logic [AC-1:0]          t_mag;
   logic [RQ_W-1:0]        rq;
   logic signed [VW-1:0]   nv_sat;
   logic signed [VW:0]     dlt;
   logic [VW:0]            dlt_mag;
   logic                   pt_chg, chg_all;
   logic                   last_j, last_i;
   logic [rbsor_pkg::ITER_W-1:0] iter_nx;

   // point loop control
   logic                   adv, iter_end, solve_end;

   // clamped grid size
   logic [AW-1:0]          n_cl;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign req_inside = (32'(req_row) <= GRID_MAX) && (32'(req_col) <= GRID_MAX);
   assign req_addr  = {AW'(req_row), AW'(req_col)};
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pt_addr   = {ri_ff, cj_ff};

   always_comb begin
      if (32'(grid_ff) < 2)              n_cl = AW'(2);
      else if (32'(grid_ff) > GRID_MAX)  n_cl = AW'(GRID_MAX);
      else                               n_cl = AW'(grid_ff);
   end

   // stencil read order: center, south, north, east, west
   always_comb begin
      fld_raddr = ctr_addr_ff;
      if (state_ff == S_RD) begin
         unique case (k_ff)
            3'd0:    fld_raddr = pt_addr;
            3'd1:    fld_raddr = {ri_ff + 1'b1, cj_ff};
            3'd2:    fld_raddr = {ri_ff - 1'b1, cj_ff};
            3'd3:    fld_raddr = {ri_ff, cj_ff + 1'b1};
            3'd4:    fld_raddr = {ri_ff, cj_ff - 1'b1};
            default: fld_raddr = pt_addr;
         endcase
      end
   end

   // single write port: loads while idle, relaxed point in the write step
   always_comb begin
      fld_we    = 1'b0;
      src_we    = 1'b0;
      fld_waddr = req_addr;
      fld_wdata = req_field_value;
      if (req_xfer && req_func == rbsor_pkg::FUNC_LOAD && req_inside) begin
         fld_we = 1'b1;
         src_we = 1'b1;
      end else if (state_ff == S_WR) begin
         fld_we    = 1'b1;
         fld_waddr = pt_addr;
         fld_wdata = nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fld_we) fld_mem[fld_waddr] <= fld_wdata;
      if (src_we) src_mem[req_addr] <= req_source_value;
      fld_rdata_ff <= fld_mem[fld_raddr];
      src_rdata_ff <= src_mem[pt_addr];
   end

   // multiplier operands: (1-gamma)*old, gamma*sum, gamma*g
   assign gam_s = signed'({1'b0, relax_ff});
   always_comb begin
      unique case (state_ff)
         S_M1: begin
            mul_a = {{2{old_ff[VW-1]}}, old_ff};
            mul_b = signed'(rbsor_pkg::ONE_Q16) - gam_s;
         end
         S_M2: begin
            mul_a = sum_ff;
            mul_b = gam_s;
         end
         default: begin
            mul_a = {{2{g_ff[VW-1]}}, g_ff};
            mul_b = gam_s;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // source term magnitude plus half of N^2 for rounding
   assign prod_mag  = prod_ff[MW-1] ? MW'(-prod_ff) : MW'(prod_ff);
   assign div_numer = prod_mag + MW'(n2_ff >> 1);
   assign div_start = (state_ff == S_DIV);

   rbsor_div #(
      .NUM_W (MW),
      .DEN_W (ADR_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (n2_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // round by 2^18 to nearest, ties away from zero, then saturate
   always_comb begin
      t_mag = t_ff[AC-1] ? AC'(-t_ff) : AC'(t_ff);
      rq    = RQ_W'((t_mag + AC'(1 << (rbsor_pkg::FRAC_SH - 1))) >> rbsor_pkg::FRAC_SH);
      if (t_ff[AC-1]) begin
         if (rq > RQ_W'(33'h1_0000_0000 >> 1)) nv_sat = {1'b1, {(VW-1){1'b0}}};
         else                                  nv_sat = -signed'(rq[VW-1:0]);
      end else begin
         if (rq > RQ_W'(32'h7FFF_FFFF))        nv_sat = {1'b0, {(VW-1){1'b1}}};
         else                                  nv_sat = signed'(rq[VW-1:0]);
      end
   end

   // per-point change against tolerance
   assign dlt     = {nv_ff[VW-1], nv_ff} - {old_ff[VW-1], old_ff};
   assign dlt_mag = dlt[VW] ? (VW+1)'(-dlt) : (VW+1)'(dlt);
   assign pt_chg  = (state_ff == S_WR) && (dlt_mag > (VW+1)'(tol_ff));
   assign chg_all = changed_ff || pt_chg;
   assign last_j  = (cj_ff == n_ff - 1'b1);
   assign last_i  = (ri_ff == n_ff - 1'b1);
   assign iter_nx = iter_ff + 1'b1;

   // step past a skipped or written point; last point of the black pass ends the iteration
   assign adv       = (state_ff == S_PT && (ri_ff[0] ^ cj_ff[0]) != parity_ff)
                      || state_ff == S_WR;
   assign iter_end  = last_j && last_i && parity_ff;
   assign solve_end = iter_end && (!chg_all || iter_nx == maxit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         relax_ff     <= rbsor_pkg::RELAX_RST;
         tol_ff       <= rbsor_pkg::TOL_RST;
         maxit_ff     <= rbsor_pkg::MAXIT_RST;
         grid_ff      <= rbsor_pkg::GRID_RST;
         iter_ff      <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               rbsor_pkg::CSR_RELAX: relax_ff <= csr_data[rbsor_pkg::GAM_W-1:0];
               rbsor_pkg::CSR_TOL:   tol_ff   <= csr_data[rbsor_pkg::TOL_W-1:0];
               rbsor_pkg::CSR_MAXIT: maxit_ff <= csr_data[rbsor_pkg::ITER_W-1:0];
               rbsor_pkg::CSR_GRID:  grid_ff  <= csr_data[rbsor_pkg::GS_W-1:0];
               default: ;
            endcase
         end

         // output register: loaded with a new result, cleared once taken
         if ((state_ff == S_RDRSP || state_ff == S_REPORT) && slot_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  ctr_addr_ff <= req_addr;
                  inside_ff   <= req_inside;
                  if (req_func == rbsor_pkg::FUNC_READ) state_ff <= S_RA;
                  else if (req_last_load)                state_ff <= S_SETUP;
               end
            end
            // read item: address issued, then data registered
            S_RA: state_ff <= S_RB;
            S_RB: begin
               old_ff   <= inside_ff ? fld_rdata_ff : '0;
               state_ff <= S_RDRSP;
            end
            S_RDRSP: begin
               if (slot_free) begin
                  rsp_kind_ff  <= rbsor_pkg::KIND_READ;
                  rsp_value_ff <= old_ff;
                  rsp_iter_ff  <= '0;
                  rsp_conv_ff  <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            S_SETUP: begin
               n_ff       <= n_cl;
               n2_ff      <= ADR_W'(n_cl) * ADR_W'(n_cl);
               iter_ff    <= '0;
               changed_ff <= 1'b0;
               parity_ff  <= 1'b0;
               ri_ff      <= AW'(1);
               cj_ff      <= AW'(1);
               if (maxit_ff == '0) state_ff <= S_REPORT;
               else                state_ff <= S_PT;
            end
            default: ;
         endcase

         // point loop: skip the other color, else read the stencil
         if (state_ff == S_PT && (ri_ff[0] ^ cj_ff[0]) == parity_ff) begin
            k_ff     <= '0;
            state_ff <= S_RD;
         end

         if (state_ff == S_RD) begin
            if (k_ff == 3'd0)      sum_ff <= '0;
            else if (k_ff == 3'd1) old_ff <= fld_rdata_ff;
            else                   sum_ff <= sum_ff + fld_rdata_ff;
            k_ff <= k_ff + 1'b1;
            if (k_ff == 3'd4) state_ff <= S_RDL;
         end
         if (state_ff == S_RDL) begin
            sum_ff   <= sum_ff + fld_rdata_ff;
            g_ff     <= src_rdata_ff;
            state_ff <= S_M1;
         end
         if (state_ff == S_M1) begin
            prod_ff  <= mul_p;
            state_ff <= S_M2;
         end
         if (state_ff == S_M2) begin
            acc_ff   <= AC'(prod_ff) <<< 2;
            prod_ff  <= mul_p;
            state_ff <= S_M3;
         end
         if (state_ff == S_M3) begin
            acc_ff   <= acc_ff + AC'(prod_ff);
            prod_ff  <= mul_p;
            state_ff <= S_DIV;
         end
         if (state_ff == S_DIV) begin
            neg_ff   <= prod_ff[MW-1];
            state_ff <= S_DIVW;
         end
         if (state_ff == S_DIVW && div_done) begin
            if (neg_ff) t_ff <= acc_ff + signed'(AC'(div_quot));
            else        t_ff <= acc_ff - signed'(AC'(div_quot));
            state_ff <= S_RND;
         end
         if (state_ff == S_RND) begin
            nv_ff    <= nv_sat;
            state_ff <= S_WR;
         end

         // advance to the next point, color or iteration
         if (adv) begin
            changed_ff <= (iter_end && !solve_end) ? 1'b0 : chg_all;
            state_ff   <= solve_end ? S_REPORT : S_PT;
            if (!last_j) begin
               cj_ff <= cj_ff + 1'b1;
            end else begin
               cj_ff <= AW'(1);
               if (!last_i) begin
                  ri_ff <= ri_ff + 1'b1;
               end else begin
                  ri_ff <= AW'(1);
                  if (!parity_ff) begin
                     parity_ff <= 1'b1;
                  end else begin
                     parity_ff <= 1'b0;
                     iter_ff   <= iter_nx;
                  end
               end
            end
         end

         if (state_ff == S_REPORT && slot_free) begin
            rsp_kind_ff  <= rbsor_pkg::KIND_REPORT;
            rsp_value_ff <= '0;
            rsp_iter_ff  <= iter_ff;
            rsp_conv_ff  <= (iter_ff != '0) && !changed_ff;
            state_ff     <= S_IDLE;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_point_value     = rsp_value_ff;
   assign rsp_iteration_count = rsp_iter_ff;
   assign rsp_converged       = rsp_conv_ff;
endmodule
`default_nettype wire

@@ design/rbsor_div.sv @@
// bit-serial restoring divider with unsigned operands, one quotient bit per cycle
`default_nettype none
module rbsor_div #(
   parameter int NUM_W = rbsor_pkg::MUL_W,
   parameter int DEN_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, denom};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

@@ bench/red_black_sor_poisson_solver_test.sv @@
// testbench for the red-black sor poisson solver: predictor, scoreboard and random traffic
`timescale 1ns / 1ps
module red_black_sor_poisson_solver_test;
   localparam int SIDE = rbsor_pkg::GRID_MAX_DEF + 1;
   localparam int VW   = rbsor_pkg::VAL_W;
   localparam int IW   = rbsor_pkg::ITER_W;
   localparam int STALL_LIMIT = 150000;   // cycles with no transfer before giving up

   typedef struct {
      logic                 kind;
      logic signed [VW-1:0] value;
      logic [IW-1:0]        count;
      logic                 conv;
   } solver_result_type;

   // scoreboard: private copy of the grid and registers, queue of pending results
   class sor_scoreboard;
      int                grid_f [SIDE*SIDE];
      int                grid_g [SIDE*SIDE];
      int unsigned       gamma_q16, tol, iter_limit, size_reg;
      solver_result_type pending_q[$];
      int                mismatches, checked, solves, converged_solves;

      function new();
         gamma_q16 = 65536; tol = 17; iter_limit = 10000; size_reg = 100;
      endfunction

      function void write_reg(logic [rbsor_pkg::CSR_A_W-1:0] idx,
                              logic [rbsor_pkg::CSR_W-1:0] data);
         case (idx)
            rbsor_pkg::CSR_RELAX: gamma_q16  = data[rbsor_pkg::GAM_W-1:0];
            rbsor_pkg::CSR_TOL:   tol        = data[rbsor_pkg::TOL_W-1:0];
            rbsor_pkg::CSR_MAXIT: iter_limit = data[rbsor_pkg::ITER_W-1:0];
            rbsor_pkg::CSR_GRID:  size_reg   = data[rbsor_pkg::GS_W-1:0];
            default: ;
         endcase
      endfunction

      // divide with rounding to nearest, ties away from zero
      function longint round_div(longint num, longint den);
         longint mag, q;
         mag = (num < 0) ? -num : num;
         q = (mag + den / 2) / den;
         return (num < 0) ? -q : q;
      endfunction

      // one color pass over the interior, returns 1 if any point moved past tol
      function bit relax_color(int n, int parity);
         longint gm, old_v, nbr, acc, srcq, nv, d;
         bit moved;
         gm = gamma_q16;
         moved = 0;
         for (int i = 1; i < n; i++)
            for (int j = 1; j < n; j++) begin
               if (((i + j) & 1) != parity) continue;
               old_v = grid_f[i*SIDE+j];
               nbr = longint'(grid_f[(i+1)*SIDE+j]) + grid_f[(i-1)*SIDE+j]
                     + grid_f[i*SIDE+j+1] + grid_f[i*SIDE+j-1];
               acc = 4 * (65536 - gm) * old_v + gm * nbr;
               srcq = round_div(gm * longint'(grid_g[i*SIDE+j]), longint'(n) * n);
               nv = round_div(acc - srcq, longint'(1) << rbsor_pkg::FRAC_SH);
               if (nv > 64'sd2147483647) nv = 64'sd2147483647;
               if (nv < -64'sd2147483648) nv = -64'sd2147483648;
               d = nv - old_v;
               if (d < 0) d = -d;
               if (d > longint'(tol)) moved = 1;
               grid_f[i*SIDE+j] = int'(nv);
            end
         return moved;
      endfunction

      // an accepted input item: update the grid and queue any result it causes
      function void note_item(logic func, int row, int col, int fv, int sv, logic last);
         solver_result_type r;
         int n, iters;
         bit moved, stop;
         if (func == rbsor_pkg::FUNC_READ) begin
            r = '{rbsor_pkg::KIND_READ, grid_f[row*SIDE+col], '0, 1'b0};
            pending_q.push_back(r);
            return;
         end
         grid_f[row*SIDE+col] = fv;
         grid_g[row*SIDE+col] = sv;
         if (!last) return;
         n = (size_reg < 2) ? 2 : (size_reg > SIDE - 1 ? SIDE - 1 : size_reg);
         iters = 0; moved = 0; stop = 0;
         while (!stop && iters < iter_limit) begin
            moved = relax_color(n, 0);
            moved = relax_color(n, 1) | moved;
            iters++;
            stop = !moved;
         end
         r = '{rbsor_pkg::KIND_REPORT, '0, IW'(iters), (iters > 0 && !moved)};
         solves++;
         if (r.conv) converged_solves++;
         pending_q.push_back(r);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(solver_result_type got);
         solver_result_type want;
         checked++;
         if (pending_q.size() == 0) begin
            report_mismatch("results pending", 1, 0);
            return;
         end
         want = pending_q.pop_front();
         if (got.kind !== want.kind) report_mismatch("result_kind", got.kind, want.kind);
         if (got.value !== want.value) report_mismatch("point_value", got.value, want.value);
         if (got.count !== want.count)
            report_mismatch("iteration_count", got.count, want.count);
         if (got.conv !== want.conv) report_mismatch("converged", got.conv, want.conv);
      endtask
   endclass

   logic                              clock, reset;
   logic                              req_valid, req_stall, req_func, req_last_load;
   logic [rbsor_pkg::IDX_W-1:0]       req_row, req_col;
   logic signed [VW-1:0]              req_field_value, req_source_value;
   logic                              rsp_valid, rsp_stall, rsp_result_kind, rsp_converged;
   logic signed [VW-1:0]              rsp_point_value;
   logic [IW-1:0]                     rsp_iteration_count;
   logic                              csr_write_en;
   logic [rbsor_pkg::CSR_A_W-1:0]     csr_index;
   logic [rbsor_pkg::CSR_W-1:0]       csr_data;

   red_black_sor_poisson_solver dut (.*);

   sor_scoreboard sb = new();
   bit loaded [SIDE*SIDE];   // points written so far, the only ones ever read
   int loaded_list[$];
   int items_sent;
   bit quiet;                // no random gaps or stalls on either side while set
   bit hold_request;         // asks the receiver for one long hold-off
   bit saw_hold_backpressure;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: checks each result transfer, stalls at random, long hold-off on request
   initial begin
      int hold_left;
      solver_result_type got;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_result_kind, rsp_point_value, rsp_iteration_count, rsp_converged};
            sb.check_result(got);
         end
         if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            if (req_valid && req_stall) saw_hold_backpressure = 1;
            rsp_stall <= 1'b1;
         end else if (quiet)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 30) ? 1'b1
                         : ($urandom_range(99) < 3);
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // offer one item and wait for its transfer
   task send_item(logic func, int row, int col, int fv, int sv, logic last);
      int gap;
      gap = 0;
      if (!quiet) begin
         case ($urandom_range(9))
            0, 1, 2:    gap = $urandom_range(1, 3);
            3:          gap = $urandom_range(10, 40);
            default:    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_row          <= row[rbsor_pkg::IDX_W-1:0];
      req_col          <= col[rbsor_pkg::IDX_W-1:0];
      req_field_value  <= fv;
      req_source_value <= sv;
      req_last_load    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(func, row, col, fv, sv, last);
      items_sent++;
      if (func == rbsor_pkg::FUNC_LOAD && !loaded[row*SIDE+col]) begin
         loaded[row*SIDE+col] = 1;
         loaded_list.push_back(row*SIDE+col);
      end
   endtask

   task load_point(int row, int col, int fv, int sv, logic last);
      send_item(rbsor_pkg::FUNC_LOAD, row, col, fv, sv, last);
   endtask

   task read_point(int row, int col, logic last);
      send_item(rbsor_pkg::FUNC_READ, row, col, $urandom, $urandom, last);
   endtask

   // field or source value: mostly modest magnitudes so solves settle, sometimes full range
   function int pick_value();
      case ($urandom_range(9))
         0:       return int'($urandom);
         1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(32'h02000000)) - 32'sh01000000;
      endcase
   endfunction

   // let the block drain, then idle before touching registers
   task drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task set_regs(int unsigned relax, int unsigned tol, int unsigned maxit, int unsigned gsize);
      int unsigned vals[4];
      logic [rbsor_pkg::CSR_A_W-1:0] idx[4];
      vals = '{relax, tol, maxit, gsize};
      idx  = '{rbsor_pkg::CSR_RELAX, rbsor_pkg::CSR_TOL, rbsor_pkg::CSR_MAXIT,
               rbsor_pkg::CSR_GRID};
      for (int k = 0; k < 4; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[k];
         csr_data     <= vals[k][rbsor_pkg::CSR_W-1:0];
         @(posedge clock);
         sb.write_reg(idx[k], vals[k][rbsor_pkg::CSR_W-1:0]);
      end
      csr_write_en <= 1'b0;
   endtask

   // write every point of the grid in use; the final one starts a solve when start is set
   task fill_grid(int n, bit start);
      for (int i = 0; i <= n; i++)
         for (int j = 0; j <= n; j++)
            load_point(i, j, pick_value(), pick_value(),
                       start && i == n && j == n);
   endtask

   task read_any(logic last);
      int p;
      p = loaded_list[$urandom_range(loaded_list.size() - 1)];
      read_point(p / SIDE, p % SIDE, last);
   endtask

   initial begin
      int n, relax, tol, maxit, phases;
      reset = 1'b1;
      req_valid = 1'b0; req_func = rbsor_pkg::FUNC_LOAD; req_row = '0; req_col = '0;
      req_field_value = '0; req_source_value = '0; req_last_load = 1'b0;
      csr_write_en = 1'b0; csr_index = rbsor_pkg::CSR_RELAX; csr_data = '0;
      quiet = 0; hold_request = 0; items_sent = 0; phases = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: grid size register below range clamps to 2, extreme values in the grid
      set_regs(65536, 17, 6, 0);
      load_point(0, 0, 32'sh7fffffff, 32'sh80000000, 1'b0);
      load_point(0, 1, 32'sh80000000, 32'sh7fffffff, 1'b0);
      load_point(0, 2, 0, -1, 1'b0);
      load_point(1, 0, -1, 0, 1'b0);
      load_point(1, 1, 32'sh01000000, 32'sh7fffffff, 1'b0);
      load_point(1, 2, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
      load_point(2, 0, 32'sh80000000, 32'sh80000000, 1'b0);
      load_point(2, 1, 32'sh7fffffff, 0, 1'b0);
      load_point(2, 2, 32'sh80000000, 32'sh12345678, 1'b1);
      read_point(1, 1, 1'b0);
      read_point(0, 0, 1'b1);                       // last flag on a read is ignored
      load_point(255, 255, 32'sh5a5a5a5a, 32'sh0f0f0f0f, 1'b0);
      read_point(255, 255, 1'b0);
      load_point(255, 0, 32'sh7fffffff, 32'sh80000000, 1'b1);  // far point still starts a solve
      drain();
      set_regs(131072, 0, 0, 1);                    // no iterations at all
      load_point(1, 1, 32'sh00800000, 0, 1'b1);
      read_point(1, 1, 1'b0);
      drain();
      set_regs(0, 16777216, 65535, 255);            // no relaxation: settles at once
      read_point(255, 255, 1'b0);
      read_point(2, 2, 1'b0);
      drain();
      set_regs(0, 16777216, 65535, 2);
      load_point(0, 2, 32'sh00400000, 32'sh7fffffff, 1'b1);
      read_point(1, 1, 1'b0);
      drain();

      // random phases with small grids
      while (items_sent < 500) begin
         phases++;
         quiet = ($urandom_range(5) == 0);
         n = $urandom_range(2, 4);
         case ($urandom_range(5))
            0:       relax = 0;
            1:       relax = 131072;
            default: relax = $urandom_range(131072);
         endcase
         case ($urandom_range(4))
            0:       tol = 0;
            1:       tol = 16777216;
            2:       tol = $urandom_range(32'h1ffffff);
            default: tol = $urandom_range(4096);
         endcase
         if (relax == 0)
            maxit = $urandom_range(65535);
         else
            maxit = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, (n == 4) ? 8 : 14);
         set_regs(relax, tol, maxit, ($urandom_range(7) == 0) ? $urandom_range(1) : n);
         if ($urandom_range(7) == 0) begin
            set_regs(relax, tol, maxit, 2);
            n = 2;
         end else if (sb.size_reg < 2)
            n = 2;
         fill_grid(n, 1'b1);
         for (int k = 0; k < 15; k++) begin
            if (k == 5 && phases % 4 == 1) begin
               hold_request = 1;                    // fill the block behind a long hold-off
               for (int m = 0; m < 12; m++) read_any(1'b0);
            end
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: read_any($urandom_range(1));
               11, 12, 13:
                  load_point($urandom_range(255), $urandom_range(255),
                             int'($urandom), int'($urandom), 1'b0);
               14, 15, 16:
                  load_point($urandom_range(n), $urandom_range(n),
                             pick_value(), pick_value(), 1'b0);
               default:
                  load_point($urandom_range(n), $urandom_range(n),
                             pick_value(), pick_value(), 1'b1);
            endcase
         end
         drain();
      end

      req_valid <= 1'b0;
      repeat (40) @(posedge clock);
      $display("covered %0d items in %0d random phases; %0d results checked",
               items_sent, phases, sb.checked);
      $display("%0d solves, %0d converged; long hold-off backed up input: %0d",
               sb.solves, sb.converged_solves, saw_hold_backpressure);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
